// ----- design/box_downsample_2x2_macros.svh -----
// ----------------------------------------------------------------------------
// box_downsample_2x2 assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_MACROS_SVH

// condition implies a consequence in the same cycle
`define BDS_ASSERT_SAME(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// condition implies a consequence in the next cycle
`define BDS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bds_pkg.sv -----
// ----------------------------------------------------------------------------
// bds_pkg
// widths, reset values and register indexes of the 2x2 box downsampler
// ----------------------------------------------------------------------------
`default_nettype none

package bds_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned PAIR_W     = 9;
  localparam int unsigned SUM_W      = 10;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned HEIGHT_MAX = 1024;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [CFG_W-1:0] DIM_MIN    = 11'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

endpackage

`default_nettype wire

// ----- design/bds_ram.sv -----
// ----------------------------------------------------------------------------
// bds_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bds_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/box_downsample_2x2.sv -----
// ----------------------------------------------------------------------------
// box_downsample_2x2
// 2x2 box-average downsampler for an 8-bit grayscale raster stream
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on the in_valid_i/in_ready_o channel in raster order, one
//   request per pixel. every lower-right pixel of an aligned 2x2 block on an
//   odd row yields one request on out_valid_o/out_ready_i carrying the
//   truncated block average, frame_end_o marks the last one of a frame.
//   frames with an odd or out-of-range width or height are consumed silently.
//   even rows store horizontal pair sums in a line ram of MAX_WIDTH/2 entries;
//   odd rows read the entry back and add their own pair in the read stage.
//   throughput is one pixel per cycle while in_ready_o is high; a result is
//   taken into the read stage by the edge that takes its pixel (ram read),
//   then moves into the output register when that is empty or being drained.
//   when the receiver stalls, one result waits in the read stage and one in
//   the output register; input stops only when both are full.
//   reset clears counters, handshakes and sets width 640, height 480; the
//   line ram needs no clearing pass. a register write restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_downsample_2x2_macros.svh"

module box_downsample_2x2 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bds_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [bds_pkg::PIX_W-1:0]     pixel_out_o,
  output logic                               frame_end_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bds_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned DW0 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW  = (DW0 > bds_pkg::CFG_W) ? DW0 : bds_pkg::CFG_W;
  localparam int unsigned XW  = (CW + 1 > AW) ? CW + 1 : AW;

  localparam logic [DW-1:0] WMAX = DW'(MAX_WIDTH);
  localparam logic [bds_pkg::CFG_W-1:0] HMAX = bds_pkg::CFG_W'(bds_pkg::HEIGHT_MAX);

  logic [bds_pkg::CFG_W-1:0] width_q, width_d;
  logic [bds_pkg::CFG_W-1:0] height_q, height_d;
  logic [CW-1:0]             col_q, col_d;
  logic [bds_pkg::ROW_W-1:0] row_q, row_d;
  logic [bds_pkg::PIX_W-1:0] held_q, held_d;

  logic [DW-1:0]             w_raw, w_clamp, col_plus;
  logic [bds_pkg::CFG_W-1:0] h_clamp, row_plus;
  logic                      frame_ok, last_col, last_row;
  logic                      in_accept, odd_col, odd_row;
  logic [XW-1:0]             col_half;
  logic [AW-1:0]             line_addr;
  logic [bds_pkg::PAIR_W-1:0] pair;
  logic                      wr_en, rd_en;
  logic [bds_pkg::PAIR_W-1:0] line_rdata;

  logic                      s1_valid_q, s1_valid_d;
  logic [bds_pkg::PAIR_W-1:0] s1_pair_q, s1_pair_d;
  logic                      s1_end_q, s1_end_d;
  logic                      s1_adv;
  logic [bds_pkg::SUM_W-1:0] block_sum;

  logic                      out_valid_q, out_valid_d;
  logic [bds_pkg::PIX_W-1:0] out_pix_q, out_pix_d;
  logic                      out_end_q, out_end_d;

  // frame geometry
  always_comb begin
    w_raw = DW'(width_q);
    if (w_raw < DW'(bds_pkg::DIM_MIN)) begin
      w_clamp = DW'(bds_pkg::DIM_MIN);
    end else if (w_raw > WMAX) begin
      w_clamp = WMAX;
    end else begin
      w_clamp = w_raw;
    end
    if (height_q < bds_pkg::DIM_MIN) begin
      h_clamp = bds_pkg::DIM_MIN;
    end else if (height_q > HMAX) begin
      h_clamp = HMAX;
    end else begin
      h_clamp = height_q;
    end
    frame_ok = !width_q[0] && !height_q[0]
             && (w_raw >= DW'(bds_pkg::DIM_MIN)) && (w_raw <= WMAX)
             && (height_q >= bds_pkg::DIM_MIN) && (height_q <= HMAX);
  end

  assign in_accept = in_valid_i && in_ready_o;
  assign odd_col   = col_q[0];
  assign odd_row   = row_q[0];
  assign col_plus  = DW'(col_q) + DW'(1);
  assign row_plus  = bds_pkg::CFG_W'(row_q) + bds_pkg::CFG_W'(1);
  assign last_col  = col_plus >= w_clamp;
  assign last_row  = row_plus >= h_clamp;
  assign col_half  = XW'(col_q) >> 1;
  assign line_addr = col_half[AW-1:0];
  assign pair      = bds_pkg::PAIR_W'(held_q) + bds_pkg::PAIR_W'(pixel_in_i);

  assign wr_en = in_accept && odd_col && !odd_row;
  assign rd_en = in_accept && odd_col && odd_row && frame_ok;

  bds_ram #(
    .WIDTH (bds_pkg::PAIR_W),
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (line_addr),
    .wdata_i (pair),
    .re_i    (rd_en),
    .raddr_i (line_addr),
    .rdata_o (line_rdata)
  );

  // read stage and output register
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign block_sum  = bds_pkg::SUM_W'(line_rdata) + bds_pkg::SUM_W'(s1_pair_q);

  always_comb begin
    width_d     = width_q;
    height_d    = height_q;
    col_d       = col_q;
    row_d       = row_q;
    held_d      = held_q;
    s1_valid_d  = s1_valid_q;
    s1_pair_d   = s1_pair_q;
    s1_end_d    = s1_end_q;
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_end_d   = out_end_q;

    if (s1_adv) begin
      out_valid_d = 1'b1;
      out_pix_d   = block_sum[bds_pkg::SUM_W-1:2];
      out_end_d   = s1_end_q;
      s1_valid_d  = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (in_accept) begin
      if (!odd_col) begin
        held_d = pixel_in_i;
      end
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_plus[bds_pkg::ROW_W-1:0];
      end else begin
        col_d = col_plus[CW-1:0];
      end
    end

    if (rd_en) begin
      s1_valid_d = 1'b1;
      s1_pair_d  = pair;
      s1_end_d   = last_col && last_row;
    end

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bds_pkg::REG_FRAME_WIDTH:  width_d  = cfg_data_i;
        bds_pkg::REG_FRAME_HEIGHT: height_d = cfg_data_i;
        default:                   width_d  = width_q;
      endcase
      col_d  = '0;
      row_d  = '0;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= bds_pkg::WIDTH_RST;
      height_q    <= bds_pkg::HEIGHT_RST;
      col_q       <= '0;
      row_q       <= '0;
      held_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      held_q      <= held_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pair_q <= s1_pair_d;
    s1_end_q  <= s1_end_d;
    out_pix_q <= out_pix_d;
    out_end_q <= out_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign frame_end_o = out_end_q;

  `BDS_ASSERT_SAME(a_col_in_frame, 1'b1, DW'(col_q) < w_clamp, "column beyond frame width")
  `BDS_ASSERT_SAME(a_row_in_frame, 1'b1, bds_pkg::CFG_W'(row_q) < h_clamp, "row beyond frame height")
  `BDS_ASSERT_SAME(a_no_rw_overlap, wr_en || rd_en, !(wr_en && rd_en), "line ram read and write")
  `BDS_ASSERT_NEXT(a_read_lands, rd_en, s1_valid_q, "line ram read lost")
  `BDS_ASSERT_NEXT(a_stage_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_pair_q),
                   "stalled result dropped")

endmodule

`default_nettype wire

// ----- verif/box_downsample_checker.sv -----
// ----------------------------------------------------------------------------
// box_downsample_checker
// watches the pixel, result and register ports of the 2x2 box downsampler,
// predicts every block average and compares it with the result stream
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_checker #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     pixel_in_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     pixel_out_i,
  input  wire logic                          frame_end_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [bds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bds_pkg::CFG_W-1:0]     cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  import bds_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] avg;
    logic             last;
  } block_avg_t;

  logic [CFG_W-1:0]  width_q;
  logic [CFG_W-1:0]  height_q;
  logic [PAIR_W-1:0] pair_sums [MAX_WIDTH/2];
  logic [PIX_W-1:0]  left_pixel;
  logic [ROW_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  block_avg_t        expected_avgs [$];
  block_avg_t        want;
  block_avg_t        got;
  bit                emit;
  int                errors = 0;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit geometry_ok();
    return !width_q[0] && !height_q[0] &&
           width_q >= DIM_MIN && width_q <= MAX_WIDTH &&
           height_q >= DIM_MIN && height_q <= HEIGHT_MAX;
  endfunction

  task automatic restart_frame();
    left_pixel = '0;
    col_q      = '0;
    row_q      = '0;
  endtask

  task automatic average_step(input logic [PIX_W-1:0] pix, output bit found,
                              output block_avg_t res);
    logic [CFG_W-1:0]  w;
    logic [CFG_W-1:0]  h;
    logic [PAIR_W-1:0] pair;
    logic [SUM_W-1:0]  sum;
    int                idx;
    found = 1'b0;
    res   = '0;
    w     = clamp_dim(width_q, CFG_W'(MAX_WIDTH));
    h     = clamp_dim(height_q, CFG_W'(HEIGHT_MAX));
    idx   = int'(col_q >> 1);
    if (!col_q[0]) begin
      left_pixel = pix;
    end else if (idx < MAX_WIDTH / 2) begin
      pair = left_pixel + pix;
      if (!row_q[0]) begin
        pair_sums[idx] = pair;
      end else if (geometry_ok()) begin
        sum      = pair_sums[idx] + pair;
        res.avg  = sum[SUM_W-1:2];
        res.last = (row_q + CFG_W'(1) >= h) && (col_q + CFG_W'(1) >= w);
        found    = 1'b1;
      end
    end
    if (col_q + CFG_W'(1) >= w) begin
      col_q = '0;
      row_q = (row_q + CFG_W'(1) >= h) ? '0 : row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  = WIDTH_RST;
      height_q = HEIGHT_RST;
      restart_frame();
      expected_avgs.delete();
      pending_o    <= 0;
      fail_count_o <= errors;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.avg  = pixel_out_i;
        got.last = frame_end_i;
        if (expected_avgs.size() == 0) begin
          $display("%0t: unexpected result, expected none, got pixel %0d frame_end %0b",
                   $time, got.avg, got.last);
          errors++;
        end else begin
          want = expected_avgs.pop_front();
          if (got.avg !== want.avg) begin
            $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                     $time, want.avg, got.avg);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: frame_end mismatch, expected %0b, got %0b",
                     $time, want.last, got.last);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH: begin
            width_q = cfg_data_i;
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_q = cfg_data_i;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        average_step(pixel_in_i, emit, want);
        if (emit) expected_avgs.push_back(want);
      end
      pending_o    <= expected_avgs.size();
      fail_count_o <= errors;
    end
  end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives raster pixel streams and frame geometry writes into the 2x2 box
// downsampler with random idling on both channels, while a checker compares
// every block average against its own prediction
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  import bds_pkg::*;

  localparam int unsigned MAX_W      = 1024;
  localparam int          CYCLE_LIMIT = 400000;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     pixel_in_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     pixel_out_o;
  logic                 frame_end_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data_i  = '0;

  int   fail_count;
  int   pending;
  int   cycles         = 0;
  int   framed_pixels  = 0;
  int   dropped_pixels = 0;
  int   geometries     = 0;
  bit   calm           = 1'b0;
  bit   hold_token     = 1'b0;
  bit   hold_seen      = 1'b0;
  int   hold_left      = 0;
  logic [PIX_W-1:0] directed_px [$];

  box_downsample_2x2 #(
    .MAX_WIDTH (MAX_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .frame_end_o (frame_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  box_downsample_checker #(
    .MAX_WIDTH (MAX_W)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .pixel_in_i   (pixel_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_out_i  (pixel_out_o),
    .frame_end_i  (frame_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_token != hold_seen) begin
      hold_seen   <= hold_token;
      hold_left   <= 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 38);
    end
  end

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic int wild_dim();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 1;
      2:       return $urandom_range(1025, 2047);
      default: return 2 * $urandom_range(1, 12);
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    while (!calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic feed(input int n, input bit framed);
    repeat (n) send_pixel(pick_pixel());
    if (framed) framed_pixels += n;
    else dropped_pixels += n;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= CFG_W'(w);
    @(posedge clk_i);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= CFG_W'(h);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    geometries++;
  endtask

  task automatic send_directed();
    foreach (directed_px[i]) send_pixel(directed_px[i]);
    framed_pixels += directed_px.size();
  endtask

  initial begin
    int w;
    int h;
    int n;
    int sel;
    int random_items;
    random_items = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // part of the first row under the reset geometry, no results yet
    feed(24, 1'b1);
    settle();

    // saturated, zero, truncating and alternating-bit blocks
    set_frame(4, 4);
    directed_px = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd1,
                    8'd1, 8'd2, 8'd3, 8'd4, 8'd128, 8'd127, 8'd170, 8'd85};
    send_directed();
    settle();
    // smallest frame
    set_frame(2, 2);
    directed_px = '{8'd1, 8'd2, 8'd3, 8'd3};
    send_directed();
    settle();
    // odd width, frame dropped
    set_frame(3, 2);
    feed(6, 1'b0);
    settle();

    // output held off while pixels keep coming
    set_frame(8, 8);
    hold_token <= ~hold_token;
    feed(64, 1'b1);
    settle();

    // all-ones and zero register values
    set_frame(2047, 0);
    feed(8, 1'b0);
    settle();

    // long frame with no idling on either side
    calm <= 1'b1;
    set_frame(32, 8);
    feed(256, 1'b1);
    settle();
    calm <= 1'b0;

    // widest setting, first row only
    set_frame(1024, 2);
    feed(40, 1'b1);
    settle();

    // tallest setting, first rows only
    set_frame(2, 1024);
    feed(64, 1'b1);
    settle();

    while (random_items < 400) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        w = 2 * $urandom_range(1, 16);
        h = 2 * $urandom_range(1, 8);
        n = w * h * $urandom_range(1, 3);
        // sometimes cut the frame short
        if ($urandom_range(4) == 0) n = $urandom_range(1, n);
        set_frame(w, h);
        feed(n, 1'b1);
        random_items += n;
      end else if (sel < 85) begin
        w = $urandom_range(1, 24);
        h = $urandom_range(1, 12);
        if (w % 2 == 0 && h % 2 == 0) begin
          if ($urandom_range(1) == 0) w++;
          else h++;
        end
        set_frame(w, h);
        feed($urandom_range(1, w * h + w), 1'b0);
      end else begin
        w = wild_dim();
        h = wild_dim();
        if (w >= 2 && w <= 1024 && w % 2 == 0 && h >= 2 && h <= 1024 && h % 2 == 0)
          w = 0;
        set_frame(w, h);
        feed($urandom_range(1, 60), 1'b0);
      end
      settle();
    end

    $display("%0d pixels in well-formed frames, %0d in dropped frames, %0d geometries",
             framed_pixels, dropped_pixels, geometries);
    $display("covered smallest frame, widest and tallest settings, odd and out-of-range sizes");
    $display("cut frames, a long output stall and a stretch with no idling");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
